// ===== sv/dtf_pkg.sv =====
// Shared types, widths and constants for the decimal text to fixed-point block.
package dtf_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned INT_W         = 16;
  localparam int unsigned FRAC_W        = 30;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned QUOT_W        = 17;
  localparam int unsigned DEN_W         = 30;
  localparam int unsigned NUM_W         = 46;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned MAX_FRAC_DIGITS = 9;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // 10^n for n = 0..9
  function automatic logic [DEN_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [DEN_W-1:0] r;
    unique case (n)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/dtf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the fraction rounding.
module dtf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dtf_pkg::NUM_W-1:0]   num,
  input  logic [dtf_pkg::DEN_W-1:0]   den,
  output dtf_pkg::div_stat_t          stat,
  output logic [dtf_pkg::QUOT_W-1:0]  quot
);

  logic                        busy;
  logic                        done;
  logic [dtf_pkg::STEP_W-1:0]  cnt;
  logic [dtf_pkg::DEN_W-1:0]   rem;
  logic [dtf_pkg::DEN_W-1:0]   dsr;
  logic [dtf_pkg::QUOT_W-1:0]  sh;

  logic [dtf_pkg::DEN_W:0]     trial;
  logic [dtf_pkg::DEN_W:0]     diff;
  logic                        qbit;
  logic [dtf_pkg::DEN_W-1:0]   rem_next;

  // quotient fits in QUOT_W bits, so the top numerator bits seed the remainder
  always_comb begin
    trial    = {rem, sh[dtf_pkg::QUOT_W-1]};
    diff     = trial - {1'b0, dsr};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? diff[dtf_pkg::DEN_W-1:0] : trial[dtf_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == dtf_pkg::STEP_W'(dtf_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= {1'b0, num[dtf_pkg::NUM_W-1:dtf_pkg::QUOT_W]};
      sh  <= num[dtf_pkg::QUOT_W-1:0];
      dsr <= den;
    end else if (busy) begin
      rem <= rem_next;
      sh  <= {sh[dtf_pkg::QUOT_W-2:0], qbit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = sh;

endmodule

// ===== sv/decimal_text_to_fixed_unit.sv =====
// Top level: ASCII decimal string to signed 16.16 fixed-point value.
// Timing: a non-NUL character is absorbed in the cycle it is accepted; the
//   result follows the terminating NUL through the divider load, the divider
//   steps, the done handoff and the output register.
// Throughput: one character per cycle while in_stall is low; after a NUL, input
//   stalls while the divider rounds the fraction, longer if the result waits.
// Reset: synchronous, active high; parser returns to start of string, output empty.
module decimal_text_to_fixed_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dtf_pkg::CH_W-1:0]           ch,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dtf_pkg::VALUE_W-1:0] value,
  output logic                               rejected
);

  // parser phases
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_INT    = 3'd1;
  localparam logic [2:0] PH_FRAC   = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_REJECT = 3'd4;

  // sequencer states
  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_DIV  = 2'd1;
  localparam logic [1:0] SEQ_OUT  = 2'd2;

  logic [1:0]                    seq;
  logic [2:0]                    phase;
  logic                          negative;
  logic [dtf_pkg::INT_W-1:0]     int_acc;
  logic [dtf_pkg::FRAC_W-1:0]    frac_acc;
  logic [dtf_pkg::CNT_W-1:0]     frac_count;

  logic [2:0]                    phase_next;
  logic                          negative_next;
  logic [dtf_pkg::INT_W-1:0]     int_acc_next;
  logic [dtf_pkg::FRAC_W-1:0]    frac_acc_next;
  logic [dtf_pkg::CNT_W-1:0]     frac_count_next;

  // item held while the divider runs
  logic                          pend_neg;
  logic                          pend_rej;
  logic [dtf_pkg::INT_W-1:0]     pend_int;

  logic                          accept;
  logic                          is_nul;
  logic                          digit;
  logic [dtf_pkg::CNT_W-1:0]     d;
  logic [dtf_pkg::CNT_W-1:0]     cnt_inc;
  logic [dtf_pkg::CNT_W-1:0]     n_digits;
  logic [dtf_pkg::DEN_W-1:0]     den;
  logic [dtf_pkg::NUM_W-1:0]     num;
  logic                          div_start;
  dtf_pkg::div_stat_t            div_stat;
  logic [dtf_pkg::QUOT_W-1:0]    quot;
  logic [dtf_pkg::VALUE_W-1:0]   mag;
  logic [dtf_pkg::VALUE_W-1:0]   result;
  logic                          out_free;

  assign in_stall  = (seq != SEQ_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_nul    = (ch == dtf_pkg::CH_NUL);
  assign div_start = accept && is_nul;
  assign out_free  = !out_valid || !out_stall;

  assign digit   = (ch >= dtf_pkg::CH_ZERO) && (ch <= dtf_pkg::CH_NINE);
  assign d       = dtf_pkg::CNT_W'(ch - dtf_pkg::CH_ZERO);
  assign cnt_inc = frac_count + 1'b1;

  // next parser state for a non-NUL character
  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    int_acc_next    = int_acc;
    frac_acc_next   = frac_acc;
    frac_count_next = frac_count;
    unique case (phase) inside
      PH_START, PH_INT: begin
        if (digit) begin
          // x*10 = x*8 + x*2, wraps mod 2^16
          int_acc_next = (int_acc << 3) + (int_acc << 1)
                         + dtf_pkg::INT_W'(d);
          phase_next   = PH_INT;
        end else if (ch == dtf_pkg::CH_MINUS && phase == PH_START) begin
          negative_next = 1'b1;
          phase_next    = PH_INT;
        end else if (ch == dtf_pkg::CH_POINT) begin
          phase_next = PH_FRAC;
        end else begin
          phase_next = PH_REJECT;
        end
      end
      PH_FRAC: begin
        if (frac_count >= dtf_pkg::CNT_W'(dtf_pkg::MAX_FRAC_DIGITS)) begin
          phase_next = PH_SKIP;
        end else if (digit) begin
          frac_acc_next   = (frac_acc << 3) + (frac_acc << 1)
                            + dtf_pkg::FRAC_W'(d);
          frac_count_next = cnt_inc;
          if (cnt_inc >= dtf_pkg::CNT_W'(dtf_pkg::MAX_FRAC_DIGITS)) begin
            phase_next = PH_SKIP;
          end
        end else begin
          phase_next = PH_REJECT;
        end
      end
      PH_SKIP, PH_REJECT: begin
        phase_next = phase;
      end
      default: begin
        phase_next = PH_REJECT;
      end
    endcase
  end

  // rounding operands: (frac * 2^16 + 10^n / 2) / 10^n
  always_comb begin
    n_digits = (frac_count > 4'd9) ? 4'd9 : frac_count;
    den      = dtf_pkg::pow10(n_digits);
    num      = {frac_acc, 16'd0} + dtf_pkg::NUM_W'(den >> 1);
  end

  dtf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .stat  (div_stat),
    .quot  (quot)
  );

  // fraction is ORed into the integer part, then the sign applied
  always_comb begin
    mag    = {pend_int, 16'd0} | dtf_pkg::VALUE_W'(quot);
    result = pend_neg ? (~mag + 1'b1) : mag;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      negative   <= 1'b0;
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_count <= '0;
    end else if (accept) begin
      if (is_nul) begin
        phase      <= PH_START;
        negative   <= 1'b0;
        int_acc    <= '0;
        frac_acc   <= '0;
        frac_count <= '0;
      end else begin
        phase      <= phase_next;
        negative   <= negative_next;
        int_acc    <= int_acc_next;
        frac_acc   <= frac_acc_next;
        frac_count <= frac_count_next;
      end
    end
  end

  // latch the finished number at the NUL
  always_ff @(posedge clk) begin
    if (div_start) begin
      pend_neg <= negative;
      pend_int <= int_acc;
      pend_rej <= (phase == PH_REJECT);
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SEQ_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one taken this cycle
      if (seq == SEQ_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (seq)
        SEQ_IDLE: begin
          if (div_start) begin
            seq <= SEQ_DIV;
          end
        end
        SEQ_DIV: begin
          if (div_stat.done) begin
            seq <= SEQ_OUT;
          end
        end
        SEQ_OUT: begin
          if (out_free) begin
            seq <= SEQ_IDLE;
          end
        end
        default: begin
          seq <= SEQ_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (seq == SEQ_OUT && out_free) begin
      value    <= pend_rej ? '0 : result;
      rejected <= pend_rej;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for decimal_text_to_fixed_unit: streams ASCII numbers and checks each 16.16 result.
module tb_top;

  // Cycles without any accepted item before the run is declared hung. The
  // slowest legal gap is a NUL followed by the divider run, plus random
  // stalls on the result side, so this leaves a wide margin.
  localparam int HANG_LIMIT = 2000;
  // Divider latency after a NUL, rounded up for the final settle.
  localparam int SETTLE_CYCLES = 40;
  // Target count of characters over the whole run.
  localparam int CHAR_TARGET = 1150;
  // Percent of cycles on which each side idles while idling is enabled.
  localparam int IDLE_PCT = 20;

  // Parser phases of our own predictor.
  typedef enum logic [2:0] {
    PH_START,
    PH_INT,
    PH_FRAC,
    PH_SKIP,
    PH_REJECT
  } parse_phase_t;

  typedef struct {
    logic [dtf_pkg::VALUE_W-1:0] value;
    logic                        rejected;
  } fixed_result_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [dtf_pkg::CH_W-1:0]           ch = dtf_pkg::CH_NUL;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [dtf_pkg::VALUE_W-1:0] value;
  logic                               rejected;

  // Predictor state: mirrors the parser registers of the block.
  parse_phase_t                       text_phase = PH_START;
  logic                               minus_seen = 1'b0;
  logic [dtf_pkg::INT_W-1:0]          int_part = '0;
  logic [dtf_pkg::FRAC_W-1:0]         frac_part = '0;
  logic [dtf_pkg::CNT_W-1:0]          frac_digits = '0;

  fixed_result_t               pending_results[$];
  int                          error_count = 0;
  int                          chars_sent = 0;
  int                          hang_cycles = 0;
  bit                          sender_busy_only = 1'b0; // no sender idling
  bit                          receiver_no_stall = 1'b0; // no receiver stalls

  decimal_text_to_fixed_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .rejected  (rejected)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Value at the NUL: fraction rounded to 16 bits, ORed (not added) under
  // the integer part, then negated modulo 2^32 if a leading minus was seen.
  function automatic logic [dtf_pkg::VALUE_W-1:0] fixed_from_parts();
    logic [63:0] divisor;
    logic [63:0] rounded;
    logic [dtf_pkg::VALUE_W-1:0] v;
    int n;
    n = (frac_digits > 4'd9) ? 9 : int'(frac_digits);
    divisor = 64'd1;
    for (int i = 0; i < n; i++) divisor = divisor * 64'd10;
    rounded = (({34'd0, frac_part} << 16) + (divisor >> 1)) / divisor;
    v = {int_part, 16'd0} | rounded[dtf_pkg::VALUE_W-1:0];
    if (minus_seen) v = -v;
    return v;
  endfunction

  // Advance the predicted parser by one accepted character.
  task automatic absorb_char(input logic [dtf_pkg::CH_W-1:0] c);
    logic is_digit;
    logic [3:0] d;
    logic [31:0] int_next;
    logic [63:0] frac_next;
    fixed_result_t r;
    is_digit = (c >= dtf_pkg::CH_ZERO) && (c <= dtf_pkg::CH_NINE);
    d = 4'(c - dtf_pkg::CH_ZERO);
    if (c == dtf_pkg::CH_NUL) begin
      if (text_phase == PH_REJECT) begin
        r.value = '0;
        r.rejected = 1'b1;
      end else begin
        r.value = fixed_from_parts();
        r.rejected = 1'b0;
      end
      pending_results.push_back(r);
      text_phase = PH_START;
      minus_seen = 1'b0;
      int_part = '0;
      frac_part = '0;
      frac_digits = '0;
    end else begin
      case (text_phase) inside
        PH_START, PH_INT: begin
          if (is_digit) begin
            int_next = 32'(int_part) * 32'd10 + 32'(d);
            int_part = int_next[dtf_pkg::INT_W-1:0];
            text_phase = PH_INT;
          end else if (c == dtf_pkg::CH_MINUS && text_phase == PH_START) begin
            minus_seen = 1'b1;
            text_phase = PH_INT;
          end else if (c == dtf_pkg::CH_POINT) begin
            text_phase = PH_FRAC;
          end else begin
            text_phase = PH_REJECT;
          end
        end
        PH_FRAC: begin
          if (frac_digits >= dtf_pkg::MAX_FRAC_DIGITS) begin
            text_phase = PH_SKIP;
          end else if (is_digit) begin
            frac_next = 64'(frac_part) * 64'd10 + 64'(d);
            frac_part = frac_next[dtf_pkg::FRAC_W-1:0];
            frac_digits = frac_digits + 1'b1;
            if (frac_digits >= dtf_pkg::MAX_FRAC_DIGITS) text_phase = PH_SKIP;
          end else begin
            text_phase = PH_REJECT;
          end
        end
        PH_SKIP, PH_REJECT: ;
        default: text_phase = PH_REJECT;
      endcase
    end
  endtask

  // Input monitor: every accepted character goes through the predictor.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) absorb_char(ch);
  end

  // Result side: random stalls, and each accepted result is checked
  // against the oldest prediction.
  always @(posedge clk) begin
    fixed_result_t want;
    out_stall <= !receiver_no_stall && ($urandom_range(99) < IDLE_PCT);
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d rejected %0b", value, rejected);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), value);
          error_count++;
        end
        if (rejected !== want.rejected) begin
          $error("rejected: expected %0b, got %0b", want.rejected, rejected);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
    if (hang_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one character. Valid is left high on return so back-to-back
  // items need no drop; a drain, or an idle cycle at the start of the next call, lowers it.
  task automatic send_char(input logic [dtf_pkg::CH_W-1:0] c);
    while (!sender_busy_only && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // Text followed by the NUL terminator.
  task automatic send_number(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(dtf_pkg::CH_NUL);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Occasionally swap one position for a random non-NUL byte (noise).
  function automatic logic [dtf_pkg::CH_W-1:0] maybe_corrupt(
      input logic [dtf_pkg::CH_W-1:0] c, input int pos, input int bad_pos);
    return (pos == bad_pos) ? dtf_pkg::CH_W'($urandom_range(1, 255)) : c;
  endfunction

  // One random number: mostly well-formed, with optional minus, integer
  // digits that may wrap, an optional point and fraction digits that may
  // run past the nine-digit limit into the ignored tail.
  task automatic send_random_number();
    int n_int;
    int n_frac;
    int bad_pos;
    int pos;
    bit has_point;
    logic [dtf_pkg::CH_W-1:0] c;
    n_int = $urandom_range(6);
    n_frac = $urandom_range(12);
    has_point = 1'($urandom_range(1));
    bad_pos = ($urandom_range(99) < 15) ? int'($urandom_range(n_int + n_frac + 1)) : -1;
    pos = 0;
    if ($urandom_range(3) == 0) begin
      send_char(maybe_corrupt(dtf_pkg::CH_MINUS, pos, bad_pos));
      pos++;
    end
    for (int i = 0; i < n_int; i++) begin
      c = dtf_pkg::CH_W'(dtf_pkg::CH_ZERO + $urandom_range(9));
      send_char(maybe_corrupt(c, pos, bad_pos));
      pos++;
    end
    if (has_point) begin
      send_char(maybe_corrupt(dtf_pkg::CH_POINT, pos, bad_pos));
      pos++;
      for (int i = 0; i < n_frac; i++) begin
        // past the digit limit anything but NUL is ignored
        if (i >= dtf_pkg::MAX_FRAC_DIGITS) c = dtf_pkg::CH_W'($urandom_range(1, 255));
        else c = dtf_pkg::CH_W'(dtf_pkg::CH_ZERO + $urandom_range(9));
        send_char(maybe_corrupt(c, pos, bad_pos));
        pos++;
      end
    end
    send_char(dtf_pkg::CH_NUL);
  endtask

  // Corner cases: empty text, lone minus, lone point, a minus after the
  // first byte, byte 255 as a stray, a full fraction that rounds up to one
  // with an ignored tail, and a negation that wraps.
  task automatic test_corner_text();
    send_number("");
    send_number("-");
    send_number(".");
    send_number("-3-");
    send_char(8'h31);
    send_char(8'hFF);
    send_char(dtf_pkg::CH_NUL);
    send_number(".999999999Z");
    send_number("-32768");
    drain_results();
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_no_idle_stream();
    sender_busy_only = 1'b1;
    receiver_no_stall = 1'b1;
    for (int n = 0; n < 20; n++) send_random_number();
    drain_results();
    sender_busy_only = 1'b0;
    receiver_no_stall = 1'b0;
  endtask

  // Sender holds off after each number until its result is out.
  task automatic test_drain_between_numbers();
    for (int n = 0; n < 10; n++) begin
      send_random_number();
      drain_results();
    end
  endtask

  task automatic test_random_text();
    while (chars_sent < CHAR_TARGET) send_random_number();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_text();
    test_no_idle_stream();
    test_drain_between_numbers();
    test_random_text();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
